>>> rtl/header_stop_frame_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the header and stop byte frame receiver
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HEADER_STOP_FRAME_RECEIVER_TOP_MACROS_SVH
`define HEADER_STOP_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define HSFR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HSFR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HSFR_ASSERT_IMP(label, clk, rst, ante, cons)
`define HSFR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/hsfr_pkg.sv
// ----------------------------------------------------------------------------
// Header and stop byte frame receiver package
// Register map, widths and reset values shared by the receiver.
// ----------------------------------------------------------------------------
package hsfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int BYTE_W     = 8;
  localparam int TIME_W     = 32;
  localparam int PIDX_W     = 6;
  localparam int LEN_W      = 7;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_HDR_ONE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HDR_TWO   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HDR_THREE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STOP      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LEN       = 3'd4;

  localparam logic [LEN_W-1:0] PAYLOAD_LEN_RESET = 7'd64;

  localparam logic [1:0] HDR_ONE_SEEN = 2'd1;
  localparam logic [1:0] HDR_TWO_SEEN = 2'd2;
  localparam logic [1:0] HDR_ALL_SEEN = 2'd3;

endpackage

>>> rtl/header_stop_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// Header and stop byte frame receiver
// Each accepted item gives a registered result item in the next cycle.
// Throughput: one item per cycle; the result register is reloaded whenever it
// is empty or being taken, so the input side stalls only on a held result.
// Reset: synchronous, clears the frame state, the last frame time and the
// configuration registers (payload length back to 64 bytes).
// ----------------------------------------------------------------------------
`include "header_stop_frame_receiver_top_macros.svh"

module header_stop_frame_receiver_top #(
  parameter int MAX_PAYLOAD = hsfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hsfr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hsfr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hsfr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hsfr_pkg::BYTE_W-1:0]      rx_byte,
  input  logic [hsfr_pkg::TIME_W-1:0]      time_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             payload_valid,
  output logic [hsfr_pkg::PIDX_W-1:0]      payload_index,
  output logic [hsfr_pkg::BYTE_W-1:0]      payload_byte,
  output logic                             frame_done,
  output logic [hsfr_pkg::TIME_W-1:0]      frame_gap,
  output logic                             frame_error
);
  import hsfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_DATA, PH_STOP} phase_t;

  logic [BYTE_W-1:0] header_byte_one;
  logic [BYTE_W-1:0] header_byte_two;
  logic [BYTE_W-1:0] header_byte_three;
  logic [BYTE_W-1:0] stop_byte_value;
  logic [LEN_W-1:0]  payload_len;

  phase_t            phase, phase_next;
  logic [1:0]        header_count, header_count_next;
  logic [CNT_W-1:0]  data_count, data_count_next;
  logic [TIME_W-1:0] last_frame_time, last_frame_time_next;

  logic              pv_next, done_next, err_next;
  logic [PIDX_W-1:0] pidx_next;
  logic [BYTE_W-1:0] pbyte_next;
  logic [TIME_W-1:0] interval_next;

  logic [CNT_W-1:0]     eff_len;
  logic [CNT_W-1:0]     data_count_inc;
  logic                 in_accept;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    case (cfg_idx)
      REG_HDR_ONE:   prdata = CFG_DATA_W'(header_byte_one);
      REG_HDR_TWO:   prdata = CFG_DATA_W'(header_byte_two);
      REG_HDR_THREE: prdata = CFG_DATA_W'(header_byte_three);
      REG_STOP:      prdata = CFG_DATA_W'(stop_byte_value);
      REG_LEN:       prdata = CFG_DATA_W'(payload_len);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    if (payload_len == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(payload_len) > MAX_PAYLOAD) begin
      eff_len = CNT_W'(MAX_PAYLOAD);
    end else begin
      eff_len = CNT_W'(payload_len);
    end
  end

  assign data_count_inc = data_count + CNT_W'(1);

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    data_count_next      = data_count;
    last_frame_time_next = last_frame_time;
    pv_next              = 1'b0;
    pidx_next            = '0;
    pbyte_next           = '0;
    done_next            = 1'b0;
    interval_next        = '0;
    err_next             = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == header_byte_one) begin
          header_count_next = HDR_ONE_SEEN;
          phase_next        = PH_HEADER;
        end else begin
          header_count_next = '0;
          data_count_next   = '0;
        end
      end
      PH_HEADER: begin
        if (header_count == HDR_ONE_SEEN && rx_byte == header_byte_two) begin
          header_count_next = HDR_TWO_SEEN;
        end else if (header_count == HDR_TWO_SEEN && rx_byte == header_byte_three) begin
          header_count_next = HDR_ALL_SEEN;
          data_count_next   = '0;
          phase_next        = PH_DATA;
        end else begin
          phase_next        = PH_IDLE;
          header_count_next = '0;
          data_count_next   = '0;
          err_next          = 1'b1;
        end
      end
      PH_DATA: begin
        if (data_count < eff_len) begin
          pv_next         = 1'b1;
          pidx_next       = PIDX_W'(data_count);
          pbyte_next      = rx_byte;
          data_count_next = data_count_inc;
          if (data_count_inc == eff_len) begin
            phase_next = PH_STOP;
          end
        end else begin
          phase_next        = PH_IDLE;
          header_count_next = '0;
          data_count_next   = '0;
        end
      end
      PH_STOP: begin
        phase_next        = PH_IDLE;
        header_count_next = '0;
        data_count_next   = '0;
        if (rx_byte == stop_byte_value) begin
          done_next            = 1'b1;
          interval_next        = time_ms - last_frame_time;
          last_frame_time_next = time_ms;
        end else begin
          err_next = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte_one   <= '0;
      header_byte_two   <= '0;
      header_byte_three <= '0;
      stop_byte_value   <= '0;
      payload_len       <= PAYLOAD_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_HDR_ONE:   header_byte_one   <= pwdata[BYTE_W-1:0];
        REG_HDR_TWO:   header_byte_two   <= pwdata[BYTE_W-1:0];
        REG_HDR_THREE: header_byte_three <= pwdata[BYTE_W-1:0];
        REG_STOP:      stop_byte_value   <= pwdata[BYTE_W-1:0];
        REG_LEN:       payload_len       <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_count    <= '0;
      data_count      <= '0;
      last_frame_time <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (in_accept) begin
        phase           <= phase_next;
        header_count    <= header_count_next;
        data_count      <= data_count_next;
        last_frame_time <= last_frame_time_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_accept) begin
      payload_valid <= pv_next;
      payload_index <= pidx_next;
      payload_byte  <= pbyte_next;
      frame_done    <= done_next;
      frame_gap     <= interval_next;
      frame_error   <= err_next;
    end
  end

  `HSFR_ASSERT_IMP(a_one_flag, clk, rst, out_valid,
                   $onehot0({payload_valid, frame_done, frame_error}))
  `HSFR_ASSERT_IMP(a_idle_clear, clk, rst, phase == PH_IDLE, header_count == '0 && data_count == '0)
  `HSFR_ASSERT_IMP(a_data_hdr, clk, rst, phase == PH_DATA || phase == PH_STOP,
                   header_count == HDR_ALL_SEEN)
  `HSFR_ASSERT_NXT(a_time_kept, clk, rst, in_accept && done_next,
                   frame_done && last_frame_time == $past(time_ms))

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the header and stop byte frame receiver
// Sends bytes with timestamps through the valid/ready input, predicts every
// result item with a behavioural decoder of the frame state machine and
// compares each result field by field. Register settings change between
// phases of differing sender and receiver idling, and one long receiver
// hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import hsfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ROUNDS      = 12;
  localparam int ROUND_ITEMS = 108;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

  typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_DATA, RX_STOP} rx_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic [TIME_W-1:0] stamp;
  } rx_item_t;

  typedef struct packed {
    logic              pay_valid;
    logic [PIDX_W-1:0] pay_index;
    logic [BYTE_W-1:0] pay_byte;
    logic              done;
    logic [TIME_W-1:0] interval;
    logic              err;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     rx_byte = '0;
  logic [TIME_W-1:0]     time_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  payload_valid;
  logic [PIDX_W-1:0]     payload_index;
  logic [BYTE_W-1:0]     payload_byte;
  logic                  frame_done;
  logic [TIME_W-1:0]     frame_gap;
  logic                  frame_error;

  header_stop_frame_receiver_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .time_ms(time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .payload_valid(payload_valid), .payload_index(payload_index),
    .payload_byte(payload_byte), .frame_done(frame_done),
    .frame_gap(frame_gap), .frame_error(frame_error)
  );

  // Register copies and frame state of the decoder
  logic [BYTE_W-1:0] hdr_one, hdr_two, hdr_three, stop_val;
  logic [LEN_W-1:0]  len_reg;
  rx_phase_t         rx_phase;
  logic [1:0]        hdr_seen;
  logic [LEN_W-1:0]  data_seen;
  logic [TIME_W-1:0] last_good_ms;

  rx_item_t      pending_q[$];
  frame_result_t expected_q[$];
  int queued_total = 0;
  int accepted_total = 0;
  int results_seen = 0;
  int fail_count = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int payload_seen = 0;
  int reg_writes = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  int cycle_count = 0;
  logic [TIME_W-1:0] now_ms = '0;

  function automatic logic [LEN_W-1:0] frame_len();
    if (len_reg == 0) begin
      return LEN_W'(1);
    end
    if (len_reg > MAX_PAYLOAD_DEF) begin
      return LEN_W'(MAX_PAYLOAD_DEF);
    end
    return len_reg;
  endfunction

  function automatic void back_to_idle();
    rx_phase  = RX_IDLE;
    hdr_seen  = '0;
    data_seen = '0;
  endfunction

  function automatic frame_result_t decode_byte(input logic [BYTE_W-1:0] b,
                                                input logic [TIME_W-1:0] t);
    frame_result_t r;
    logic [LEN_W-1:0] len;
    r = '0;
    len = frame_len();
    case (rx_phase)
      RX_IDLE: begin
        if (b == hdr_one) begin
          hdr_seen = HDR_ONE_SEEN;
          rx_phase = RX_HEADER;
        end
      end
      RX_HEADER: begin
        if (hdr_seen == HDR_ONE_SEEN && b == hdr_two) begin
          hdr_seen = HDR_TWO_SEEN;
        end else if (hdr_seen == HDR_TWO_SEEN && b == hdr_three) begin
          hdr_seen  = HDR_ALL_SEEN;
          data_seen = '0;
          rx_phase  = RX_DATA;
        end else begin
          back_to_idle();
          r.err = 1'b1;
        end
      end
      RX_DATA: begin
        if (data_seen < len) begin
          r.pay_valid = 1'b1;
          r.pay_index = data_seen[PIDX_W-1:0];
          r.pay_byte  = b;
          data_seen   = data_seen + 1'b1;
          if (data_seen == len) begin
            rx_phase = RX_STOP;
          end
        end else begin
          back_to_idle();
        end
      end
      default: begin
        if (b == stop_val) begin
          r.done       = 1'b1;
          r.interval   = t - last_good_ms;
          last_good_ms = t;
        end else begin
          r.err = 1'b1;
        end
        back_to_idle();
      end
    endcase
    good_frames  += r.done;
    bad_frames   += r.err;
    payload_seen += r.pay_valid;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] v);
    return v + BYTE_W'($urandom_range(1, 255));
  endfunction

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Input driver
  always @(posedge clk) begin
    rx_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(decode_byte(rx_byte, time_ms));
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = pending_q.pop_front();
          rx_byte  <= nxt.rx;
          time_ms  <= nxt.stamp;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once after a number of result items
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_used && results_seen == 150) begin
      hold_used <= 1'b1;
      hold_left <= 200;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("payload_valid", TIME_W'(want.pay_valid), TIME_W'(payload_valid));
          check_field("payload_index", TIME_W'(want.pay_index), TIME_W'(payload_index));
          check_field("payload_byte", TIME_W'(want.pay_byte), TIME_W'(payload_byte));
          check_field("frame_done", TIME_W'(want.done), TIME_W'(frame_done));
          check_field("frame_gap", want.interval, frame_gap);
          check_field("frame_error", TIME_W'(want.err), TIME_W'(frame_error));
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
    logic [CFG_DATA_W-1:0] keep;
    keep = (idx == REG_LEN) ? 32'h7F : 32'hFF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & ~keep) | (CFG_DATA_W'(val) & keep);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HDR_ONE:   hdr_one   = val;
      REG_HDR_TWO:   hdr_two   = val;
      REG_HDR_THREE: hdr_three = val;
      REG_STOP:      stop_val  = val;
      REG_LEN:       len_reg   = val[LEN_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic push_at(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t);
    now_ms = t;
    pending_q.push_back('{rx: b, stamp: t});
    queued_total++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 31) == 0) begin
      push_at(b, $urandom());
    end else begin
      push_at(b, now_ms + TIME_W'($urandom_range(0, 20)));
    end
  endtask

  task automatic push_random_sequence();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    len = int'(frame_len());
    if (kind >= 92) begin
      repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom_range(0, 255)));
    end else begin
      push_byte(hdr_one);
      if (kind >= 70 && kind < 78) begin
        push_byte(other_than(hdr_two));
      end else begin
        push_byte(hdr_two);
        if (kind >= 78 && kind < 84) begin
          push_byte(other_than(hdr_three));
        end else begin
          push_byte(hdr_three);
          repeat (len) push_byte(BYTE_W'($urandom_range(0, 255)));
          push_byte(kind < 70 ? stop_val : other_than(stop_val));
        end
      end
    end
  endtask

  task automatic drain();
    while (accepted_total != queued_total || expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic configure_round(input int r);
    logic [7:0] len;
    case (r % 6)
      0: len = 8'd1;
      1: len = 8'd64;
      2: len = 8'd0;
      3: len = 8'd127;
      default: len = 8'($urandom_range(1, 8));
    endcase
    if (r % 4 == 1) begin
      cfg_write(REG_HDR_ONE, 8'h00);
      cfg_write(REG_HDR_TWO, 8'h00);
      cfg_write(REG_HDR_THREE, 8'h00);
      cfg_write(REG_STOP, 8'h00);
    end else if (r % 4 == 3) begin
      cfg_write(REG_HDR_ONE, 8'hFF);
      cfg_write(REG_HDR_TWO, 8'hFF);
      cfg_write(REG_HDR_THREE, 8'hFF);
      cfg_write(REG_STOP, 8'hFF);
    end else begin
      cfg_write(REG_HDR_ONE, 8'($urandom_range(0, 255)));
      cfg_write(REG_HDR_TWO, 8'($urandom_range(0, 255)));
      cfg_write(REG_HDR_THREE, 8'($urandom_range(0, 255)));
      cfg_write(REG_STOP, 8'($urandom_range(0, 255)));
    end
    cfg_write(REG_LEN, len);
    if (r % 5 == 2) begin
      cfg_write(REG_UNMAPPED, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int target;
    hdr_one      = '0;
    hdr_two      = '0;
    hdr_three    = '0;
    stop_val     = '0;
    len_reg      = PAYLOAD_LEN_RESET;
    last_good_ms = '0;
    back_to_idle();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    cfg_write(REG_HDR_ONE, 8'hFF);
    cfg_write(REG_HDR_TWO, 8'h00);
    cfg_write(REG_HDR_THREE, 8'hA5);
    cfg_write(REG_STOP, 8'h5A);
    cfg_write(REG_LEN, 8'd1);
    cfg_write(REG_UNMAPPED, 8'h77);
    push_at(8'h12, 32'h0);
    push_at(8'hFF, 32'h1);
    push_at(8'h00, 32'h2);
    push_at(8'hA5, 32'h3);
    push_at(8'h00, 32'h4);
    push_at(8'h5A, 32'hFFFF_FFFF);
    // A failed second header byte equal to the first is not taken as a new start.
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h22);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hA5);
    push_byte(8'hFF);
    push_byte(8'h00);
    drain();
    // Shrinking the payload length below the bytes already taken ends the frame.
    cfg_write(REG_LEN, 8'd4);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hA5);
    repeat (3) push_byte(BYTE_W'($urandom_range(0, 255)));
    drain();
    cfg_write(REG_LEN, 8'd2);
    push_byte(8'h5A);
    drain();

    for (int r = 0; r < ROUNDS; r++) begin
      case (r / 3)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_gap_pct = 88;
          stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 88;
        end
        default: begin
          send_gap_pct = 16;
          stall_pct = 16;
        end
      endcase
      configure_round(r);
      target = queued_total + ROUND_ITEMS;
      while (queued_total < target) push_random_sequence();
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Checked %0d result items under %0d register writes and four idling mixes.",
             results_seen, reg_writes);
    $display("Frames completed: %0d, frame errors: %0d, payload bytes: %0d.",
             good_frames, bad_frames, payload_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hsfr_pkg.sv
rtl/header_stop_frame_receiver_top.sv
verif/tb_top.sv
